// File: hdl/sls_pkg.sv
package sls_pkg;

  // glyph string capacity and the widths that follow from it
  localparam int MAX_GLYPHS = 16;
  localparam int GLYPH_W    = $clog2(MAX_GLYPHS);
  localparam int ROWS       = 8;
  localparam int ROW_W      = 3;
  localparam int PIX_W      = 8;
  localparam int STORE_DEPTH = MAX_GLYPHS * ROWS;
  localparam int ADDR_W     = $clog2(STORE_DEPTH);
  localparam int COUNT_W    = 5;
  localparam int DWELL_W    = 8;
  localparam int SEL_W      = 4;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // request kinds carried on tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_GLYPH_COUNT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DWELL_SCANS = 1'b1;

  // register reset values
  localparam logic [COUNT_W-1:0] GLYPH_COUNT_RST = 5'd1;
  localparam logic [DWELL_W-1:0] DWELL_SCANS_RST = 8'd10;

  // blank row (active low)
  localparam logic [PIX_W-1:0] BLANK_ROW = 8'hFF;

  // scan position handed from the scan controller to the datapath
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   shift;
    logic [GLYPH_W-1:0] cur_glyph;
    logic [GLYPH_W-1:0] nxt_glyph;
  } scan_pos_t;

endpackage

// File: hdl/sls_scan_ctrl.sv
module sls_scan_ctrl
  import sls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  tick_acc,
  output scan_pos_t             pos
);

  logic [COUNT_W-1:0] glyph_count_r;
  logic [DWELL_W-1:0] dwell_scans_r;
  logic [ROW_W-1:0]   scan_row_r, scan_row_nxt;
  logic [DWELL_W-1:0] scan_repeat_r, scan_repeat_nxt;
  logic [ROW_W-1:0]   shift_r, shift_nxt;
  logic [GLYPH_W-1:0] cur_glyph_r, cur_glyph_nxt;

  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W-1:0] succ_sum;
  logic [GLYPH_W-1:0] succ_glyph;
  logic [DWELL_W-1:0] eff_dwell;
  logic [DWELL_W-1:0] repeat_inc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_count_r <= GLYPH_COUNT_RST;
      dwell_scans_r <= DWELL_SCANS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_GLYPH_COUNT: glyph_count_r <= cfg_wdata[COUNT_W-1:0];
        CFG_DWELL_SCANS: dwell_scans_r <= cfg_wdata[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp glyph count to 1..MAX_GLYPHS and find the following glyph
  always_comb begin
    if (glyph_count_r == '0) begin
      eff_count = COUNT_W'(1);
    end else if (glyph_count_r > COUNT_W'(MAX_GLYPHS)) begin
      eff_count = COUNT_W'(MAX_GLYPHS);
    end else begin
      eff_count = glyph_count_r;
    end
    succ_sum   = COUNT_W'(cur_glyph_r) + COUNT_W'(1);
    succ_glyph = (succ_sum >= eff_count) ? '0 : succ_sum[GLYPH_W-1:0];
    eff_dwell  = (dwell_scans_r == '0) ? DWELL_W'(1) : dwell_scans_r;
    repeat_inc = scan_repeat_r + DWELL_W'(1);
  end

  // row, dwell, shift and glyph advance on each tick
  always_comb begin
    scan_row_nxt    = scan_row_r;
    scan_repeat_nxt = scan_repeat_r;
    shift_nxt       = shift_r;
    cur_glyph_nxt   = cur_glyph_r;
    if (tick_acc) begin
      scan_row_nxt = scan_row_r + ROW_W'(1);
      if (scan_row_r == ROW_W'(ROWS - 1)) begin
        if (repeat_inc >= eff_dwell || repeat_inc == '0) begin
          scan_repeat_nxt = '0;
          shift_nxt       = shift_r + ROW_W'(1);
          if (shift_r == ROW_W'(ROWS - 1)) begin
            cur_glyph_nxt = succ_glyph;
          end
        end else begin
          scan_repeat_nxt = repeat_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r    <= '0;
      scan_repeat_r <= '0;
      shift_r       <= '0;
      cur_glyph_r   <= '0;
    end else begin
      scan_row_r    <= scan_row_nxt;
      scan_repeat_r <= scan_repeat_nxt;
      shift_r       <= shift_nxt;
      cur_glyph_r   <= cur_glyph_nxt;
    end
  end

  assign pos.row       = scan_row_r;
  assign pos.shift     = shift_r;
  assign pos.cur_glyph = cur_glyph_r;
  assign pos.nxt_glyph = succ_glyph;

endmodule

// File: hdl/sls_glyph_ram.sv
module sls_glyph_ram
  import sls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [PIX_W-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [PIX_W-1:0]  rdata_a,
  output logic [PIX_W-1:0]  rdata_b
);

  logic [PIX_W-1:0]       mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] written_r;
  logic [PIX_W-1:0]       rd_a_r, rd_b_r;
  logic                   ok_a_r, ok_b_r;

  // glyph rows, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_a_r <= mem[raddr_a];
      rd_b_r <= mem[raddr_b];
    end
  end

  // per-row written flags; an unwritten row reads as blank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      ok_a_r    <= 1'b0;
      ok_b_r    <= 1'b0;
    end else begin
      if (we) begin
        written_r[waddr] <= 1'b1;
      end
      if (re) begin
        ok_a_r <= written_r[raddr_a];
        ok_b_r <= written_r[raddr_b];
      end
    end
  end

  assign rdata_a = ok_a_r ? rd_a_r : BLANK_ROW;
  assign rdata_b = ok_b_r ? rd_b_r : BLANK_ROW;

endmodule

// File: hdl/sls_row_merge.sv
module sls_row_merge
  import sls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick_acc,
  input  scan_pos_t             pos,
  input  logic [PIX_W-1:0]      cur_row,
  input  logic [PIX_W-1:0]      nxt_row,
  output logic                  take_ok,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic [ROW_W-1:0]      s1_row_r;
  logic [ROW_W-1:0]      s1_shift_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  advance;
  logic [2*PIX_W-1:0]    pair_shifted;
  logic [2*SEL_W-1:0]    sel_onehot;
  logic [OUT_DATA_W-1:0] result;

  // output register empties or drains this cycle
  assign advance = !out_valid_r || out_tready;
  assign take_ok = !s1_valid_r || advance;

  // row tag that travels with the store read
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_row_r   <= pos.row;
      s1_shift_r <= pos.shift;
    end
  end

  // current row shifted left, following glyph filling in from the right
  always_comb begin
    pair_shifted = {cur_row, nxt_row} << s1_shift_r;
    sel_onehot   = (2*SEL_W)'(1) << s1_row_r;
    result       = {pair_shifted[2*PIX_W-1:PIX_W], sel_onehot};
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid_r;
      s1_valid_nxt  = 1'b0;
    end
    if (tick_acc) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hdl/scrolling_led_matrix_scanner.sv
// Scrolling 8x8 LED matrix scanner. A load transfer (in_tuser low) writes one active-low
// row of one glyph into a 128-row store that starts blank; it produces no result. A tick
// transfer (in_tuser high) drives the next row slot: one result carries the one-hot common
// line for that row and the column data of the current glyph shifted left by the scroll
// amount, with the following glyph entering from the right. Each tick passes through the
// glyph store's registered dual read and then the result register, and the block accepts
// one item every cycle while results are taken. After dwell_scans full scans the view
// scrolls by one column, and after eight columns it moves on to the next glyph, wrapping
// at glyph_count. Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
module scrolling_led_matrix_scanner
  import sls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,   // 0 glyph_count, 1 dwell_scans
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // glyph_index[3:0], row_index[6:4],
                                            // row_bits[14:7], zero [15]
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // low_select[3:0], high_select[7:4],
                                            // pixel_data[15:8]
);

  logic              in_acc;
  logic              tick_acc;
  logic              load_acc;
  logic              take_ok;
  scan_pos_t         pos;
  logic [ADDR_W-1:0] waddr;
  logic [PIX_W-1:0]  cur_row, nxt_row;

  assign in_tready = take_ok;
  assign in_acc    = in_tvalid && take_ok;
  assign tick_acc  = in_acc && (in_tuser == REQ_TICK);
  assign load_acc  = in_acc && (in_tuser == REQ_LOAD);
  assign waddr     = {in_tdata[GLYPH_W-1:0], in_tdata[GLYPH_W+ROW_W-1:GLYPH_W]};

  sls_scan_ctrl u_scan_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .tick_acc  (tick_acc),
    .pos       (pos)
  );

  sls_glyph_ram u_glyph_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .we      (load_acc),
    .waddr   (waddr),
    .wdata   (in_tdata[GLYPH_W+ROW_W+PIX_W-1:GLYPH_W+ROW_W]),
    .re      (tick_acc),
    .raddr_a ({pos.cur_glyph, pos.row}),
    .raddr_b ({pos.nxt_glyph, pos.row}),
    .rdata_a (cur_row),
    .rdata_b (nxt_row)
  );

  sls_row_merge u_row_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_acc   (tick_acc),
    .pos        (pos),
    .cur_row    (cur_row),
    .nxt_row    (nxt_row),
    .take_ok    (take_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hdl/sls_checker.sv
module sls_checker
  import sls_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // every result drives exactly one common line
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[2*SEL_W-1:0]))
    else $error("result does not select exactly one common line");

  // input only stalls behind a full, blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output side can move");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // a blocked result keeps its value
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind scrolling_led_matrix_scanner sls_checker u_sls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
